// ===== rtl/rri_pkg.sv =====
// Shared types and constants for the ray / rectangle intersection unit.
// Used by every rtl module but rri_pdiv; depends on nothing.
package rri_pkg;

  localparam int CW       = 21;   // coordinate width, signed Q9.12
  localparam int FB       = 12;   // fraction bits
  localparam int CFG_W    = 63;   // widest configuration register
  localparam int IDX_W    = 3;
  localparam int LEN_W    = 20;
  localparam int IN_W     = 192;
  localparam int OUT_W    = 136;
  localparam int NUM_W    = 45;   // numerator / denominator sums
  localparam int DEN_W    = 43;   // divisor magnitude of the t division
  localparam int MAG_W    = 56;   // |num| << FB
  localparam int TQ_W     = 32;   // quotient bits of the t division
  localparam int UQ_W     = 17;   // quotient bits of the u / v division
  localparam int HP_W     = 42;   // clamped hit point
  localparam int REL_W    = 43;   // hit point minus corner
  localparam longint POS_LIM = 64'sd1 <<< 40;

  localparam logic [IDX_W-1:0] REG_CORNER = 3'd0;
  localparam logic [IDX_W-1:0] REG_NORMAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_UP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_RLEN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ULEN   = 3'd5;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   diff_t;

  // ray data that travels beside the t division
  typedef struct packed {
    coord_t [2:0]       org;
    coord_t [2:0]       dir;
    logic signed [31:0] tmin;
    logic signed [31:0] tmax;
    logic               neg;
    logic               dz;
    logic               ovf;
  } ray_t;

  // projection result that travels beside the u division
  typedef struct packed {
    logic               hit;
    logic signed [31:0] tval;
    coord_t [2:0]       pos;
    logic               rz;
  } res_t;

endpackage

// ===== rtl/rri_pdiv.sv =====
// Pipelined restoring divider: one quotient bit per register stage,
// with a sideband vector carried alongside. Depends on nothing.
module rri_pdiv #(
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] lo,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] q,
  output logic [SW-1:0] out_side
);

  logic [DW-1:0] rem_r  [1:QW];
  logic [QW-1:0] lo_r   [1:QW];
  logic [QW-1:0] q_r    [1:QW];
  logic [DW-1:0] den_r  [1:QW];
  logic [SW-1:0] side_r [1:QW];
  logic          vld_r  [1:QW];
  logic [DW-1:0] rem_i  [QW];
  logic [QW-1:0] lo_i   [QW];
  logic [QW-1:0] q_i    [QW];
  logic [DW-1:0] den_i  [QW];
  logic [SW-1:0] side_i [QW];
  logic          vld_i  [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic          ge      [QW];

  // stage inputs: the ports feed stage 0, registers feed the rest
  always_comb begin
    rem_i[0]  = rem0;
    lo_i[0]   = lo;
    q_i[0]    = '0;
    den_i[0]  = den;
    side_i[0] = side;
    vld_i[0]  = in_valid;
    for (int k = 1; k < QW; k++) begin
      rem_i[k]  = rem_r[k];
      lo_i[k]   = lo_r[k];
      q_i[k]    = q_r[k];
      den_i[k]  = den_r[k];
      side_i[k] = side_r[k];
      vld_i[k]  = vld_r[k];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] sub;
    for (int k = 0; k < QW; k++) begin
      trial = {rem_i[k], lo_i[k][QW-1]};
      sub   = trial - {1'b0, den_i[k]};
      ge[k] = trial >= {1'b0, den_i[k]};
      rem_nxt[k] = ge[k] ? sub[DW-1:0] : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        lo_r[k+1]   <= lo_i[k] << 1;
        q_r[k+1]    <= {q_i[k][QW-2:0], ge[k]};
        den_r[k+1]  <= den_i[k];
        side_r[k+1] <= side_i[k];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign q         = q_r[QW];
  assign out_side  = side_r[QW];

endmodule

// ===== rtl/rri_front.sv =====
// Front stages: ray minus corner, dot products with the normal, and the
// operands of the t division. Depends on rri_pkg.
module rri_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  rri_pkg::coord_t [2:0]     org,
  input  rri_pkg::coord_t [2:0]     dir,
  input  logic signed [31:0]        tmin,
  input  logic signed [31:0]        tmax,
  input  rri_pkg::coord_t [2:0]     cor,
  input  rri_pkg::coord_t [2:0]     nrm,
  output logic                      out_valid,
  output logic [rri_pkg::DEN_W-1:0] rem0,
  output logic [rri_pkg::TQ_W-1:0]  lo,
  output logic [rri_pkg::DEN_W-1:0] aden,
  output rri_pkg::ray_t             ray
);

  localparam int NW = rri_pkg::NUM_W;

  logic v1_r, v2_r, v3_r, v4_r;
  rri_pkg::diff_t [2:0] diff_r, diff_nxt;
  logic signed [NW-1:0] pn_r [3];
  logic signed [NW-1:0] pd_r [3];
  logic signed [NW-1:0] num_r, den_r;
  rri_pkg::ray_t r1_r, r2_r, r3_r, r4_r, r1_nxt, r4_nxt;
  logic [rri_pkg::DEN_W-1:0] rem0_r, aden_r, rem0_nxt, aden_nxt;
  logic [rri_pkg::TQ_W-1:0]  lo_r, lo_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_nxt[i] = rri_pkg::diff_t'(org[i]) - rri_pkg::diff_t'(cor[i]);
    end
    r1_nxt      = '0;
    r1_nxt.org  = org;
    r1_nxt.dir  = dir;
    r1_nxt.tmin = tmin;
    r1_nxt.tmax = tmax;
  end

  // magnitudes and sign of the quotient, zero-divisor and overflow flags
  always_comb begin
    logic [NW-1:0] anum;
    logic [NW-1:0] aden_w;
    logic [rri_pkg::MAG_W-1:0] mag;
    anum   = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
    aden_w = den_r[NW-1] ? NW'(-den_r) : NW'(den_r);
    mag    = {anum[rri_pkg::MAG_W-rri_pkg::FB-1:0], {rri_pkg::FB{1'b0}}};
    rem0_nxt = rri_pkg::DEN_W'(mag[rri_pkg::MAG_W-1:rri_pkg::TQ_W]);
    lo_nxt   = mag[rri_pkg::TQ_W-1:0];
    aden_nxt = aden_w[rri_pkg::DEN_W-1:0];
    r4_nxt     = r3_r;
    r4_nxt.neg = num_r[NW-1] ^ den_r[NW-1];
    r4_nxt.dz  = (den_r == '0);
    r4_nxt.ovf = rem0_nxt >= aden_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      r1_r   <= r1_nxt;
      for (int i = 0; i < 3; i++) begin
        pn_r[i] <= NW'(diff_r[i]) * NW'(nrm[i]);
        pd_r[i] <= NW'(r1_r.dir[i]) * NW'(nrm[i]);
      end
      r2_r   <= r1_r;
      num_r  <= -(pn_r[0] + pn_r[1] + pn_r[2]);
      den_r  <= pd_r[0] + pd_r[1] + pd_r[2];
      r3_r   <= r2_r;
      rem0_r <= rem0_nxt;
      lo_r   <= lo_nxt;
      aden_r <= aden_nxt;
      r4_r   <= r4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign rem0      = rem0_r;
  assign lo        = lo_r;
  assign aden      = aden_r;
  assign ray       = r4_r;

endmodule

// ===== rtl/rri_hit.sv =====
// Hit stages: saturate t, interval test, hit point, projections onto
// both edges and range check. Depends on rri_pkg.
module rri_hit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rri_pkg::TQ_W-1:0]   q,
  input  rri_pkg::ray_t              ray,
  input  rri_pkg::coord_t [2:0]      cor,
  input  rri_pkg::coord_t [2:0]      rdir,
  input  rri_pkg::coord_t [2:0]      udir,
  input  logic [rri_pkg::LEN_W-1:0]  rlen,
  input  logic [rri_pkg::LEN_W-1:0]  ulen,
  output logic                       out_valid,
  output rri_pkg::res_t              res,
  output logic [rri_pkg::LEN_W-1:0]  dx,
  output logic [rri_pkg::LEN_W-1:0]  dy,
  output logic                       uz
);

  localparam int PTW = 53;
  localparam int PRW = 64;
  localparam int SMW = 66;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [31:0] t1_r, t2_r, t3_r, t4_r, t1_nxt;
  logic ok1_r, ok2_r, ok3_r, ok4_r, ok1_nxt;
  rri_pkg::coord_t [2:0] org1_r, dir1_r, org2_r;
  logic signed [PTW-1:0]   pt_r [3];
  logic signed [rri_pkg::HP_W-1:0]  hc3_r [3];
  logic signed [rri_pkg::HP_W-1:0]  hc4_r [3];
  logic signed [rri_pkg::HP_W-1:0]  hc_nxt [3];
  logic signed [rri_pkg::REL_W-1:0] rel_r [3];
  logic signed [rri_pkg::REL_W-1:0] rel_nxt [3];
  logic signed [PRW-1:0] pr_r [3];
  logic signed [PRW-1:0] pu_r [3];
  rri_pkg::res_t res_r, res_nxt;
  logic [rri_pkg::LEN_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic uz_r;

  // saturate quotient, apply sign, test interval
  always_comb begin
    logic [31:0] qs;
    qs = (ray.ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
    if (ray.neg) begin
      t1_nxt = -$signed(qs);
    end else begin
      t1_nxt = (qs > 32'h7fff_ffff) ? 32'sh7fff_ffff : $signed(qs);
    end
    ok1_nxt = !ray.dz && (t1_nxt >= ray.tmin) && (t1_nxt <= ray.tmax);
  end

  // hit point, clamped, and its offset from the corner
  always_comb begin
    logic signed [PTW-1:0] sh;
    logic signed [PTW:0]   hraw;
    for (int i = 0; i < 3; i++) begin
      sh   = pt_r[i] >>> rri_pkg::FB;
      hraw = (PTW+1)'(sh) + (PTW+1)'(org2_r[i]);
      if (hraw > rri_pkg::POS_LIM) begin
        hc_nxt[i] = rri_pkg::HP_W'(rri_pkg::POS_LIM);
      end else if (hraw < -rri_pkg::POS_LIM) begin
        hc_nxt[i] = rri_pkg::HP_W'(-rri_pkg::POS_LIM);
      end else begin
        hc_nxt[i] = hraw[rri_pkg::HP_W-1:0];
      end
      rel_nxt[i] = rri_pkg::REL_W'(hc_nxt[i]) - rri_pkg::REL_W'(cor[i]);
    end
  end

  // projections, range check, output clamp
  always_comb begin
    logic signed [SMW-1:0] sr;
    logic signed [SMW-1:0] su;
    logic signed [SMW-1:0] px;
    logic signed [SMW-1:0] py;
    logic in_rect;
    sr = SMW'(pr_r[0]) + SMW'(pr_r[1]) + SMW'(pr_r[2]);
    su = SMW'(pu_r[0]) + SMW'(pu_r[1]) + SMW'(pu_r[2]);
    px = sr >>> rri_pkg::FB;
    py = su >>> rri_pkg::FB;
    in_rect = !px[SMW-1] && (px <= $signed({1'b0, rlen}))
           && !py[SMW-1] && (py <= $signed({1'b0, ulen}));
    res_nxt      = '0;
    res_nxt.hit  = ok4_r && in_rect;
    res_nxt.tval = t4_r;
    res_nxt.rz   = (rlen == '0);
    for (int i = 0; i < 3; i++) begin
      if (hc4_r[i] > rri_pkg::HP_W'((64'sd1 <<< (rri_pkg::CW - 1)) - 1)) begin
        res_nxt.pos[i] = {1'b0, {(rri_pkg::CW-1){1'b1}}};
      end else if (hc4_r[i] < -rri_pkg::HP_W'(64'sd1 <<< (rri_pkg::CW - 1))) begin
        res_nxt.pos[i] = {1'b1, {(rri_pkg::CW-1){1'b0}}};
      end else begin
        res_nxt.pos[i] = hc4_r[i][rri_pkg::CW-1:0];
      end
    end
    dx_nxt = px[rri_pkg::LEN_W-1:0];
    dy_nxt = py[rri_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t1_nxt;
      ok1_r  <= ok1_nxt;
      org1_r <= ray.org;
      dir1_r <= ray.dir;
      for (int i = 0; i < 3; i++) begin
        pt_r[i]  <= PTW'(t1_r) * PTW'(dir1_r[i]);
        hc3_r[i] <= hc_nxt[i];
        rel_r[i] <= rel_nxt[i];
        hc4_r[i] <= hc3_r[i];
        pr_r[i]  <= PRW'(rel_r[i]) * PRW'(rdir[i]);
        pu_r[i]  <= PRW'(rel_r[i]) * PRW'(udir[i]);
      end
      t2_r   <= t1_r;
      ok2_r  <= ok1_r;
      org2_r <= org1_r;
      t3_r   <= t2_r;
      ok3_r  <= ok2_r;
      t4_r   <= t3_r;
      ok4_r  <= ok3_r;
      res_r  <= res_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      uz_r   <= (ulen == '0);
    end
  end

  assign out_valid = v5_r;
  assign res       = res_r;
  assign dx        = dx_r;
  assign dy        = dy_r;
  assign uz        = uz_r;

endmodule

// ===== rtl/ray_rectangle_intersect_unit.sv =====
// Ray / rectangle intersection unit, top level.
// Pipeline: 4 front stages, 32-stage t divider, 5 hit stages,
// 17-stage u/v dividers and the output register. One ray per cycle;
// the whole pipeline holds while a result waits on out_tready.
// Synchronous active-low reset clears all valid bits and loads the
// register defaults (lengths 1.0, all vectors zero).
module ray_rectangle_intersect_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max, pad
  input  logic [rri_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // hit, hit_t, tex_u, tex_v, pos_x, pos_y, pos_z, pad
  output logic [rri_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [rri_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rri_pkg::CFG_W-1:0]   cfg_data
);

  logic [rri_pkg::CFG_W-1:0] corner_r, normal_r, right_r, up_r;
  logic [rri_pkg::LEN_W-1:0] rlen_r, ulen_r;
  logic en;

  logic                      f_valid;
  logic [rri_pkg::DEN_W-1:0] f_rem0, f_aden;
  logic [rri_pkg::TQ_W-1:0]  f_lo;
  rri_pkg::ray_t             f_ray;

  logic                      d_valid;
  logic [rri_pkg::TQ_W-1:0]  d_q;
  logic [$bits(rri_pkg::ray_t)-1:0] d_side;

  logic                      h_valid;
  rri_pkg::res_t             h_res;
  logic [rri_pkg::LEN_W-1:0] h_dx, h_dy;
  logic                      h_uz;

  logic                      u_valid, v_valid;
  logic [rri_pkg::UQ_W-1:0]  u_q, v_q;
  logic [$bits(rri_pkg::res_t)-1:0] u_side;
  logic                      v_side;
  rri_pkg::res_t             u_res;

  logic                      out_valid_r;
  logic [rri_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= '0;
      normal_r <= '0;
      right_r  <= '0;
      up_r     <= '0;
      rlen_r   <= rri_pkg::LEN_W'(1 << rri_pkg::FB);
      ulen_r   <= rri_pkg::LEN_W'(1 << rri_pkg::FB);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rri_pkg::REG_CORNER: corner_r <= cfg_data;
        rri_pkg::REG_NORMAL: normal_r <= cfg_data;
        rri_pkg::REG_RIGHT:  right_r  <= cfg_data;
        rri_pkg::REG_UP:     up_r     <= cfg_data;
        rri_pkg::REG_RLEN:   rlen_r   <= cfg_data[rri_pkg::LEN_W-1:0];
        rri_pkg::REG_ULEN:   ulen_r   <= cfg_data[rri_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // advance everything unless the output item is held
  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  rri_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .org       (in_tdata[62:0]),
    .dir       (in_tdata[125:63]),
    .tmin      (in_tdata[157:126]),
    .tmax      (in_tdata[189:158]),
    .cor       (corner_r),
    .nrm       (normal_r),
    .out_valid (f_valid),
    .rem0      (f_rem0),
    .lo        (f_lo),
    .aden      (f_aden),
    .ray       (f_ray)
  );

  rri_pdiv #(
    .DW (rri_pkg::DEN_W),
    .QW (rri_pkg::TQ_W),
    .SW ($bits(rri_pkg::ray_t))
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .rem0      (f_rem0),
    .lo        (f_lo),
    .den       (f_aden),
    .side      (f_ray),
    .out_valid (d_valid),
    .q         (d_q),
    .out_side  (d_side)
  );

  rri_hit u_hit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .q         (d_q),
    .ray       (d_side),
    .cor       (corner_r),
    .rdir      (right_r),
    .udir      (up_r),
    .rlen      (rlen_r),
    .ulen      (ulen_r),
    .out_valid (h_valid),
    .res       (h_res),
    .dx        (h_dx),
    .dy        (h_dy),
    .uz        (h_uz)
  );

  rri_pdiv #(
    .DW (rri_pkg::LEN_W),
    .QW (rri_pkg::UQ_W),
    .SW ($bits(rri_pkg::res_t))
  ) u_udiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_valid),
    .rem0      (h_dx >> 1),
    .lo        ({h_dx[0], {(rri_pkg::UQ_W-1){1'b0}}}),
    .den       (rlen_r),
    .side      (h_res),
    .out_valid (u_valid),
    .q         (u_q),
    .out_side  (u_side)
  );

  rri_pdiv #(
    .DW (rri_pkg::LEN_W),
    .QW (rri_pkg::UQ_W),
    .SW (1)
  ) u_vdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_valid),
    .rem0      (h_dy >> 1),
    .lo        ({h_dy[0], {(rri_pkg::UQ_W-1){1'b0}}}),
    .den       (ulen_r),
    .side      (h_uz),
    .out_valid (v_valid),
    .q         (v_q),
    .out_side  (v_side)
  );

  // zero every field on a miss; a zero edge length gives a zero coordinate
  always_comb begin
    u_res        = u_side;
    out_data_nxt = '0;
    if (u_res.hit) begin
      out_data_nxt[0]       = 1'b1;
      out_data_nxt[32:1]    = u_res.tval;
      out_data_nxt[49:33]   = u_res.rz ? '0 : u_q;
      out_data_nxt[66:50]   = v_side ? '0 : v_q;
      out_data_nxt[129:67]  = u_res.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= u_valid && v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== bench/ray_rectangle_intersect_checker.sv =====
// Checker for the ray / rectangle intersection unit: follows the register port,
// predicts one result per accepted ray and compares it with the result channel.
// Depends on rri_pkg for widths and register indexes.
module ray_rectangle_intersect_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [rri_pkg::IN_W-1:0]  in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [rri_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_wr_en,
  input  logic [rri_pkg::IDX_W-1:0] cfg_index,
  input  logic [rri_pkg::CFG_W-1:0] cfg_data,
  output int                        fails,
  output int                        pending
);

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_t;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [20:0] pos_x;
    logic [20:0] pos_y;
    logic [20:0] pos_z;
  } hit_rec_t;

  logic [rri_pkg::CFG_W-1:0] corner_r, normal_r, right_r, up_r;
  logic [rri_pkg::LEN_W-1:0] rlen_r, ulen_r;
  hit_rec_t                  hits_q[$];

  function automatic longint clampl(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic hit_rec_t trace_ray(logic [rri_pkg::IN_W-1:0] d);
    longint   org[3], dir[3], cor[3], nrm[3], rgt[3], upv[3], hp[3], rel[3];
    longint   num, den, mag, q, t, tmin, tmax, px, py;
    hit_rec_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      org[i] = $signed(d[i*rri_pkg::CW +: rri_pkg::CW]);
      dir[i] = $signed(d[(i+3)*rri_pkg::CW +: rri_pkg::CW]);
      cor[i] = $signed(corner_r[i*rri_pkg::CW +: rri_pkg::CW]);
      nrm[i] = $signed(normal_r[i*rri_pkg::CW +: rri_pkg::CW]);
      rgt[i] = $signed(right_r[i*rri_pkg::CW +: rri_pkg::CW]);
      upv[i] = $signed(up_r[i*rri_pkg::CW +: rri_pkg::CW]);
    end
    tmin = $signed(d[6*rri_pkg::CW +: 32]);
    tmax = $signed(d[6*rri_pkg::CW+32 +: 32]);
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      num -= (org[i] - cor[i]) * nrm[i];
      den += dir[i] * nrm[i];
    end
    // parallel ray: miss
    if (den == 0) return r;
    mag = ((num < 0) ? -num : num) <<< rri_pkg::FB;
    q = mag / ((den < 0) ? -den : den);
    if (q > 64'sd2147483648) q = 64'sd2147483648;
    if ((num < 0) != (den < 0)) t = -q;
    else t = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
    if (t < tmin || t > tmax) return r;
    for (int i = 0; i < 3; i++) begin
      hp[i] = clampl(org[i] + ((t * dir[i]) >>> rri_pkg::FB),
                     -rri_pkg::POS_LIM, rri_pkg::POS_LIM);
      rel[i] = hp[i] - cor[i];
    end
    px = (rel[0]*rgt[0] + rel[1]*rgt[1] + rel[2]*rgt[2]) >>> rri_pkg::FB;
    py = (rel[0]*upv[0] + rel[1]*upv[1] + rel[2]*upv[2]) >>> rri_pkg::FB;
    if (px < 0 || px > longint'(rlen_r) || py < 0 || py > longint'(ulen_r)) return r;
    r.hit   = 1'b1;
    r.hit_t = t[31:0];
    r.tex_u = (rlen_r == 0) ? '0 : 17'((px <<< 16) / longint'(rlen_r));
    r.tex_v = (ulen_r == 0) ? '0 : 17'((py <<< 16) / longint'(ulen_r));
    r.pos_x = 21'(clampl(hp[0], -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1));
    r.pos_y = 21'(clampl(hp[1], -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1));
    r.pos_z = 21'(clampl(hp[2], -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1));
    return r;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  initial fails = 0;

  always @(posedge clk) begin
    hit_rec_t want, got;
    if (!rst_n) begin
      corner_r <= '0;
      normal_r <= '0;
      right_r  <= '0;
      up_r     <= '0;
      rlen_r   <= rri_pkg::LEN_W'(4096);
      ulen_r   <= rri_pkg::LEN_W'(4096);
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rri_pkg::REG_CORNER: corner_r <= cfg_data;
          rri_pkg::REG_NORMAL: normal_r <= cfg_data;
          rri_pkg::REG_RIGHT:  right_r  <= cfg_data;
          rri_pkg::REG_UP:     up_r     <= cfg_data;
          rri_pkg::REG_RLEN:   rlen_r   <= cfg_data[rri_pkg::LEN_W-1:0];
          rri_pkg::REG_ULEN:   ulen_r   <= cfg_data[rri_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) hits_q.push_back(trace_ray(in_tdata));
      if (out_tvalid && out_tready) begin
        got.hit   = out_tdata[0];
        got.hit_t = out_tdata[32:1];
        got.tex_u = out_tdata[49:33];
        got.tex_v = out_tdata[66:50];
        got.pos_x = out_tdata[87:67];
        got.pos_y = out_tdata[108:88];
        got.pos_z = out_tdata[129:109];
        if (hits_q.size() == 0) begin
          $error("result item with no ray outstanding");
          fails++;
        end else begin
          want = hits_q.pop_front();
          compare_field("hit",   want.hit,   got.hit);
          compare_field("hit_t", $signed(want.hit_t), $signed(got.hit_t));
          compare_field("tex_u", want.tex_u, got.tex_u);
          compare_field("tex_v", want.tex_v, got.tex_v);
          compare_field("pos_x", $signed(want.pos_x), $signed(got.pos_x));
          compare_field("pos_y", $signed(want.pos_y), $signed(got.pos_y));
          compare_field("pos_z", $signed(want.pos_z), $signed(got.pos_z));
        end
      end
    end
    pending <= hits_q.size();
  end

endmodule

// ===== bench/tb_ray_rectangle_intersect_unit.sv =====
// Top of the ray / rectangle intersection testbench: clock, reset, scene
// set-up, ray stimulus with random idling and the verdict.
// Depends on rri_pkg, ray_rectangle_intersect_unit and the checker.
module tb_ray_rectangle_intersect_unit;

  localparam logic [rri_pkg::IDX_W-1:0] REG_SPARE = 3'd6;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_RAYS = 1330;

  logic                        clk, rst_n;
  logic                        in_tvalid, in_tready, out_tvalid, out_tready;
  logic [rri_pkg::IN_W-1:0]    in_tdata;
  logic [rri_pkg::OUT_W-1:0]   out_tdata;
  logic                        cfg_wr_en;
  logic [rri_pkg::IDX_W-1:0]   cfg_index;
  logic [rri_pkg::CFG_W-1:0]   cfg_data;
  int                          fails, pending;
  int                          send_idle, recv_idle, rays_sent, quiet;
  longint                      sc_cor[3], sc_rgt[3], sc_up[3], sc_rlen, sc_ulen;

  ray_rectangle_intersect_unit DUT (.*);

  ray_rectangle_intersect_checker u_checker (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  // watchdog on cycles with no item on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint sat21(longint x);
    return (x < -1048576) ? -1048576 : ((x > 1048575) ? 1048575 : x);
  endfunction

  function automatic logic [rri_pkg::IN_W-1:0] pack_ray(longint ox, oy, oz, dx, dy, dz,
                                                         tmin, tmax);
    pack_ray = '0;
    pack_ray[0 +: 126] = {dz[20:0], dy[20:0], dx[20:0], oz[20:0], oy[20:0], ox[20:0]};
    pack_ray[126 +: 64] = {tmax[31:0], tmin[31:0]};
  endfunction

  function automatic logic [rri_pkg::CFG_W-1:0] pack_vec(longint x, y, z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  function automatic logic [rri_pkg::IN_W-1:0] noise_ray();
    logic [rri_pkg::IN_W-1:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    d[rri_pkg::IN_W-1 -: 2] = '0;
    return d;
  endfunction

  // aim a ray at a random point of the current rectangle
  function automatic logic [rri_pkg::IN_W-1:0] aimed_ray();
    longint a, b, s, tg[3], dr[3], o[3], tmin, tmax;
    a = $urandom_range(sc_rlen);
    b = $urandom_range(sc_ulen);
    s = $urandom_range(1 << 16, 256);
    for (int i = 0; i < 3; i++) begin
      dr[i] = longint'($urandom_range(16384)) - 8192;
      tg[i] = sc_cor[i] + ((a * sc_rgt[i]) >>> rri_pkg::FB) + ((b * sc_up[i]) >>> rri_pkg::FB);
      o[i]  = sat21(tg[i] - ((dr[i] * s) >>> rri_pkg::FB));
    end
    tmin = ($urandom_range(3) == 0) ? s + 4096 : -longint'($urandom_range(1 << 20));
    tmax = ($urandom_range(7) == 0) ? s - 4096 : longint'($urandom_range(32'h7fffffff, s));
    return pack_ray(o[0], o[1], o[2], dr[0], dr[1], dr[2], tmin, tmax);
  endfunction

  task automatic send_ray(logic [rri_pkg::IN_W-1:0] d);
    logic rdy;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    rays_sent++;
    // step the idle pattern through its three phases
    if (rays_sent == 450) begin
      send_idle = 51; recv_idle = 13;
    end else if (rays_sent == 900) begin
      send_idle = 0;  recv_idle = 0;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [rri_pkg::IDX_W-1:0] idx, logic [rri_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_scene(longint c[3], longint r[3], longint u[3], longint n[3],
                            longint rl, longint ul);
    drain();
    write_reg(rri_pkg::REG_CORNER, pack_vec(c[0], c[1], c[2]));
    write_reg(rri_pkg::REG_NORMAL, pack_vec(n[0], n[1], n[2]));
    write_reg(rri_pkg::REG_RIGHT,  pack_vec(r[0], r[1], r[2]));
    write_reg(rri_pkg::REG_UP,     pack_vec(u[0], u[1], u[2]));
    write_reg(rri_pkg::REG_RLEN,   rri_pkg::CFG_W'(rl));
    write_reg(rri_pkg::REG_ULEN,   rri_pkg::CFG_W'(ul));
    write_reg(REG_SPARE,           {rri_pkg::CFG_W{1'b1}});
    cfg_wr_en <= 1'b0;
    sc_cor = c; sc_rgt = r; sc_up = u; sc_rlen = rl; sc_ulen = ul;
    @(posedge clk);
  endtask

  task automatic random_rays(int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      send_ray(($urandom_range(9) < 7) ? aimed_ray() : noise_ray());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 0;
    rays_sent = 0;
    send_idle = 13;
    recv_idle = 51;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset scene: zero normal, every ray parallel
    send_ray(pack_ray(5, 6, 7, 4096, 0, 0, 0, 32'h7fffffff));
    send_ray(noise_ray());

    // axis-aligned rectangle in the z = 0 plane
    load_scene('{1000, -2000, 0}, '{4096, 0, 0}, '{0, 4096, 0}, '{0, 0, 4096},
               3 * 4096, 2 * 4096);
    send_ray(pack_ray(1000, -2000, 8192, 0, 0, -4096, 0, 32'h7fffffff));     // at corner
    send_ray(pack_ray(13288, 6192, 8192, 0, 0, -4096, 0, 32'h7fffffff));     // far corner
    send_ray(pack_ray(13289, 6192, 8192, 0, 0, -4096, 0, 32'h7fffffff));     // just off
    send_ray(pack_ray(999, 0, 8192, 0, 0, -4096, 0, 32'h7fffffff));
    send_ray(pack_ray(4000, 0, 8192, 4096, 0, 0, 0, 32'h7fffffff));          // parallel
    send_ray(pack_ray(4000, 0, 8192, 0, 0, 4096, -(64'sd1 <<< 31), 32'h7fffffff));
    send_ray(pack_ray(4000, 0, 1048575, 0, 0, -1, -(64'sd1 <<< 31), 32'h7fffffff));
    send_ray(pack_ray(4000, 0, -1048576, 0, 0, 1, -(64'sd1 <<< 31), 32'h7fffffff));
    send_ray(pack_ray(4000, 0, 8192, 0, 0, -4096, 9000, 8000));             // empty interval
    send_ray(pack_ray(4000, 0, 8192, 0, 0, -4096, 8192, 8192));
    send_ray(pack_ray(4000, 0, 8192, 1048575, 1048575, -4096, 0, 32'h7fffffff));
    send_ray(pack_ray(-1048576, -1048576, -1048576, -1048576, -1048576, -1048576,
                      -(64'sd1 <<< 31), -(64'sd1 <<< 31)));
    send_ray(pack_ray(1048575, 1048575, 1048575, 1048575, 1048575, 1048575,
                      32'h7fffffff, 32'h7fffffff));
    send_ray(pack_ray(4000, 0, 4096, -1048576, 0, -1, -(64'sd1 <<< 31), 32'h7fffffff));
    random_rays(400);

    // tilted rectangle with the smallest right and largest up edge
    load_scene('{-3000, 2000, 100}, '{2896, 2896, 0}, '{0, 0, 4096}, '{2896, -2896, 0},
               1, 1048575);
    random_rays(300);
    load_scene('{-1048576, 1048575, 0}, '{0, 2896, 2896}, '{4096, 0, 0}, '{0, 2896, -2896},
               1048575, 1);
    random_rays(300);

    // every packed bit set: all components -1
    load_scene('{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, 1048575, 1048575);
    for (int k = 0; k < 30; k++) send_ray(noise_ray());
    load_scene('{500, 500, -4096}, '{0, 4096, 0}, '{0, 0, 4096}, '{4096, 0, 0},
               8 * 4096, 5 * 4096);
    random_rays(RANDOM_RAYS - 1030);

    drain();
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
